// ===== rtl/core/lrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants of the link reconnect backoff controller
// Event and result transaction layouts, register indexes, mode encoding and
// register reset values.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int unsigned MS_W    = 32;
  localparam int unsigned DELAY_W = 31;

  // Event kinds.
  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Reported link state codes.
  localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
  localparam logic [1:0] LINK_CONNECTING   = 2'd1;
  localparam logic [1:0] LINK_CONNECTED    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_BACKOFF     = 2'd0;
  localparam logic [1:0] CFG_MAX_BACKOFF     = 2'd1;
  localparam logic [1:0] CFG_CONNECT_TIMEOUT = 2'd2;

  localparam logic [DELAY_W-1:0] MIN_BACKOFF_RST     = 31'd1000;
  localparam logic [DELAY_W-1:0] MAX_BACKOFF_RST     = 31'd60000;
  localparam logic [DELAY_W-1:0] CONNECT_TIMEOUT_RST = 31'd10000;

  typedef enum logic [2:0] {
    MODE_DISC = 3'b001,
    MODE_CONN = 3'b010,
    MODE_UP   = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [MS_W-1:0] now_ms;
    logic            link_up;
  } in_t;

  typedef struct packed {
    logic [1:0]         link_state;
    logic               start_attempt;
    logic               drop_link;
    logic               retry_scheduled;
    logic [DELAY_W-1:0] retry_delay_ms;
  } out_t;

  typedef struct packed {
    logic [DELAY_W-1:0] backoff_min;
    logic [DELAY_W-1:0] backoff_max;
    logic [DELAY_W-1:0] attempt_timeout;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               has_target;
    logic [DELAY_W-1:0] backoff;
    logic [MS_W-1:0]    retry_at;
    logic [MS_W-1:0]    attempt_start;
  } state_t;

endpackage

// ===== rtl/core/lrb_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_step: next-state and result logic for one event
// Purely combinational: takes the current controller state, the registers
// and one event, and gives the next state and the result transaction.
// ----------------------------------------------------------------------------
module lrb_step (
  input  lrb_pkg::cfg_t   cfg,
  input  lrb_pkg::state_t cur,
  input  lrb_pkg::in_t    item,
  output lrb_pkg::state_t nxt,
  output lrb_pkg::out_t   res
);

  logic [lrb_pkg::MS_W-1:0]    elapsed;
  logic                        timed_out;
  logic                        retry_due;
  logic [lrb_pkg::MS_W-1:0]    retry_at_new;
  logic [lrb_pkg::MS_W-1:0]    doubled;
  logic [lrb_pkg::DELAY_W-1:0] backoff_new;

  function automatic logic [1:0] link_code(input lrb_pkg::mode_t m);
    logic [1:0] code;
    unique case (m)
      lrb_pkg::MODE_DISC: code = lrb_pkg::LINK_DISCONNECTED;
      lrb_pkg::MODE_CONN: code = lrb_pkg::LINK_CONNECTING;
      lrb_pkg::MODE_UP:   code = lrb_pkg::LINK_CONNECTED;
      default:            code = lrb_pkg::LINK_DISCONNECTED;
    endcase
    return code;
  endfunction

  // The elapsed time is taken modulo 2^32, so a wrapping timestamp is safe.
  // The retry compare is a plain unsigned compare.
  assign elapsed      = item.now_ms - cur.attempt_start;
  assign timed_out    = elapsed > {1'b0, cfg.attempt_timeout};
  assign retry_due    = item.now_ms >= cur.retry_at;
  assign retry_at_new = item.now_ms + {1'b0, cur.backoff};
  assign doubled      = {cur.backoff, 1'b0};
  assign backoff_new  = (doubled > {1'b0, cfg.backoff_max}) ?
                        cfg.backoff_max : doubled[lrb_pkg::DELAY_W-1:0];

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.operation)
      lrb_pkg::OP_START: begin
        nxt.has_target    = 1'b1;
        nxt.backoff       = cfg.backoff_min;
        nxt.mode          = lrb_pkg::MODE_CONN;
        nxt.attempt_start = item.now_ms;
        res.start_attempt = 1'b1;
      end
      lrb_pkg::OP_STOP: begin
        res.drop_link  = 1'b1;
        nxt.mode       = lrb_pkg::MODE_DISC;
        nxt.has_target = 1'b0;
      end
      lrb_pkg::OP_POLL: begin
        unique case (cur.mode)
          lrb_pkg::MODE_DISC: begin
            if (cur.has_target && retry_due) begin
              nxt.mode          = lrb_pkg::MODE_CONN;
              nxt.attempt_start = item.now_ms;
              res.start_attempt = 1'b1;
            end
          end
          lrb_pkg::MODE_CONN: begin
            if (item.link_up) begin
              nxt.mode    = lrb_pkg::MODE_UP;
              nxt.backoff = cfg.backoff_min;
            end else if (timed_out) begin
              res.drop_link       = 1'b1;
              nxt.mode            = lrb_pkg::MODE_DISC;
              nxt.retry_at        = retry_at_new;
              nxt.backoff         = backoff_new;
              res.retry_scheduled = 1'b1;
              res.retry_delay_ms  = cur.backoff;
            end
          end
          lrb_pkg::MODE_UP: begin
            // A lost link schedules a retry but does not pulse drop_link.
            if (!item.link_up) begin
              nxt.mode            = lrb_pkg::MODE_DISC;
              nxt.retry_at        = retry_at_new;
              nxt.backoff         = backoff_new;
              res.retry_scheduled = 1'b1;
              res.retry_delay_ms  = cur.backoff;
            end
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
      default: begin
        // Unused event code: state is left alone and no pulse is raised.
        nxt = cur;
      end
    endcase
    res.link_state = link_code(nxt.mode);
  end

endmodule

// ===== rtl/core/link_reconnect_backoff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff: link bring-up controller with exponential backoff
// Tracks disconnected, connecting and connected modes, times connect
// attempts and schedules retries with a doubling, saturating delay.
// ----------------------------------------------------------------------------
// The controller takes one event transaction per clock while in_stall is low
// and returns exactly one result transaction for it, registered, on the clock
// after acceptance. A new event is taken every cycle unless in_stall is high;
// the whole update (one 32-bit add, one 32-bit subtract and three compares)
// settles combinationally from event port to output register, which is the
// only stage. in_stall rises only while a result sits in the output register
// and out_stall is high. Configuration writes are always taken (cfg_ready is
// tied high) and apply to the next event that uses them; the backoff picks
// up a new minimum only on a start event or a successful connect.
module link_reconnect_backoff (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lrb_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lrb_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lrb_pkg::DELAY_W-1:0] cfg_data
);

  lrb_pkg::cfg_t   cfg_r;
  lrb_pkg::state_t state_r;
  lrb_pkg::state_t state_nxt;
  lrb_pkg::out_t   res_nxt;
  lrb_pkg::out_t   out_data_r;
  logic            out_valid_r;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lrb_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (in_data),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backoff_min     <= lrb_pkg::MIN_BACKOFF_RST;
      cfg_r.backoff_max     <= lrb_pkg::MAX_BACKOFF_RST;
      cfg_r.attempt_timeout <= lrb_pkg::CONNECT_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrb_pkg::CFG_MIN_BACKOFF:     cfg_r.backoff_min     <= cfg_data;
        lrb_pkg::CFG_MAX_BACKOFF:     cfg_r.backoff_max     <= cfg_data;
        lrb_pkg::CFG_CONNECT_TIMEOUT: cfg_r.attempt_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= lrb_pkg::MODE_DISC;
      state_r.has_target    <= 1'b0;
      state_r.backoff       <= lrb_pkg::MIN_BACKOFF_RST;
      state_r.retry_at      <= '0;
      state_r.attempt_start <= '0;
      out_valid_r           <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  // An accepted event always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted event produced no result");

  // A stop event leaves the controller disconnected with no target.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == lrb_pkg::OP_STOP) |=>
      (state_r.mode == lrb_pkg::MODE_DISC) && !state_r.has_target)
    else $error("stop did not clear the target");

  // A connect request is only issued when the result reports connecting.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.start_attempt |->
      out_data_r.link_state == lrb_pkg::LINK_CONNECTING)
    else $error("connect request without connecting state");

  // A scheduled retry always leaves the link disconnected.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.retry_scheduled |->
      (out_data_r.link_state == lrb_pkg::LINK_DISCONNECTED) &&
      (state_r.mode == lrb_pkg::MODE_DISC || $past(accept) == 1'b0))
    else $error("retry scheduled while not disconnected");

endmodule
